>>> design/positional_array_list_macros.svh
// ----------------------------------------------------------------------------
// positional_array_list assertion macros
// Concurrent check shorthands sampled on clk, disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef POSITIONAL_ARRAY_LIST_MACROS_SVH
`define POSITIONAL_ARRAY_LIST_MACROS_SVH

// same-cycle implication
`define PAL_ASSERT_IMP(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define PAL_ASSERT_NXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> design/pal_pkg.sv
// ----------------------------------------------------------------------------
// pal_pkg
// Field widths, command codes and status codes of the positional array list.
// ----------------------------------------------------------------------------
`default_nettype none

package pal_pkg;

  // port field widths
  localparam int FUNC_W     = 3;
  localparam int POS_W      = 7;
  localparam int VALUE_W    = 32;
  localparam int STATUS_W   = 3;
  localparam int FOUND_W    = 6;
  localparam int COUNT_W    = 7;
  localparam int MAX_DATA_W = 64;

  // command codes
  localparam logic [FUNC_W-1:0] FN_INSERT     = 3'd0;
  localparam logic [FUNC_W-1:0] FN_ERASE      = 3'd1;
  localparam logic [FUNC_W-1:0] FN_FIND       = 3'd2;
  localparam logic [FUNC_W-1:0] FN_MODIFY     = 3'd3;
  localparam logic [FUNC_W-1:0] FN_PUSH_BACK  = 3'd4;
  localparam logic [FUNC_W-1:0] FN_PUSH_FRONT = 3'd5;
  localparam logic [FUNC_W-1:0] FN_POP_BACK   = 3'd6;
  localparam logic [FUNC_W-1:0] FN_POP_FRONT  = 3'd7;

  // status codes
  localparam logic [STATUS_W-1:0] ST_OK       = 3'd0;
  localparam logic [STATUS_W-1:0] ST_FULL     = 3'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY    = 3'd2;
  localparam logic [STATUS_W-1:0] ST_RANGE    = 3'd3;
  localparam logic [STATUS_W-1:0] ST_NOTFOUND = 3'd4;

endpackage

`default_nettype wire

>>> design/positional_array_list.sv
// ----------------------------------------------------------------------------
// positional_array_list
// Packed ordered list of up to CAPACITY words held in a memory with one read
// and one write port, with insert, erase, find, modify, push and pop commands.
// ----------------------------------------------------------------------------
// Usage:
//   Commands enter on the in_ channel (func, position, value) under valid and
//   stall; exactly one result beat (status, found_index, count) leaves on the
//   out_ channel for each command.
//   Modify, pop back, failing commands, insert or push at the tail and erase
//   of the last entry finish in the accept cycle: the result is shown in the
//   next cycle.
//   Insert or push front with entries at or after the target moves them one
//   place up and writes the new word into the gap; erase or pop front moves
//   the entries after the target one place down; find scans from entry 0 up
//   to the last entry. The memory gives one read and one write per cycle,
//   and one compare per cycle is made on the registered read data.
//   in_stall stays high while a command is in progress and while a finished
//   result waits under out_stall; a result beat holds steady while stalled.
//   rst_n (synchronous) empties the list and drops any pending result;
//   memory contents are not cleared, entries past the count are never read.
// ----------------------------------------------------------------------------
`default_nettype none

`include "positional_array_list_macros.svh"

module positional_array_list #(
  parameter int CAPACITY   = 64,
  parameter int DATA_WIDTH = 32
) (
  input  wire                                  clk,
  input  wire                                  rst_n,
  input  wire                                  in_valid,
  output logic                                 in_stall,
  input  wire         [pal_pkg::FUNC_W-1:0]    in_func,
  input  wire         [pal_pkg::POS_W-1:0]     in_position,
  input  wire  signed [pal_pkg::VALUE_W-1:0]   in_value,
  output logic                                 out_valid,
  input  wire                                  out_stall,
  output logic        [pal_pkg::STATUS_W-1:0]  out_status,
  output logic        [pal_pkg::FOUND_W-1:0]   out_found_index,
  output logic        [pal_pkg::COUNT_W-1:0]   out_count
);

  import pal_pkg::*;

  localparam int AW = $clog2(CAPACITY);
  localparam int LW = $clog2(CAPACITY + 1);
  localparam int CW = (LW > POS_W) ? LW : POS_W;

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_SHIFT = 2'd1;
  localparam logic [1:0] S_FILL  = 2'd2;
  localparam logic [1:0] S_FIND  = 2'd3;

  // sequencer state
  logic [1:0]            state_r, state_nxt;
  logic [LW-1:0]         len_r, len_nxt;
  logic [AW-1:0]         rd_ptr_r, rd_ptr_nxt;
  logic [AW-1:0]         end_r, end_nxt;
  logic [AW-1:0]         last_r, last_nxt;
  logic [AW-1:0]         pos_r, pos_nxt;
  logic                  rd_on_r, rd_on_nxt;
  logic                  vld_r, vld_nxt;
  logic                  up_r, up_nxt;
  logic [DATA_WIDTH-1:0] word_r, word_nxt;

  // result register
  logic                  out_valid_r, out_valid_nxt;
  logic [STATUS_W-1:0]   out_status_r, out_status_nxt;
  logic [FOUND_W-1:0]    out_found_r, out_found_nxt;
  logic [COUNT_W-1:0]    out_count_r, out_count_nxt;

  // list storage
  logic [DATA_WIDTH-1:0] mem [CAPACITY];
  logic [DATA_WIDTH-1:0] mem_rd_data_r;
  logic                  mem_we;
  logic [AW-1:0]         mem_wa;
  logic [DATA_WIDTH-1:0] mem_wd;

  // decode helpers
  logic                  out_free;
  logic                  in_take;
  logic                  done;
  logic [STATUS_W-1:0]   res_status;
  logic [AW-1:0]         res_found;
  logic [MAX_DATA_W-1:0] value_ext;
  logic [DATA_WIDTH-1:0] word_in;
  logic [CW-1:0]         len_c;
  logic [CW-1:0]         pos_c;
  logic [CW-1:0]         ins_pos_c;
  logic [CW-1:0]         del_pos_c;
  logic                  full;
  logic                  empty;

  // handshake
  assign out_free  = !out_valid_r || !out_stall;
  assign in_stall  = (state_r != S_IDLE) || !out_free;
  assign in_take   = in_valid && !in_stall;

  // operand preparation
  assign value_ext = {(MAX_DATA_W - VALUE_W)'(0), in_value};
  assign word_in   = value_ext[DATA_WIDTH-1:0];
  assign len_c     = CW'(len_r);
  assign pos_c     = CW'(in_position);
  assign full      = (len_r == LW'(CAPACITY));
  assign empty     = (len_r == '0);

  // effective target for the insert and erase families
  always_comb begin
    case (in_func)
      FN_INSERT:    ins_pos_c = pos_c;
      FN_PUSH_BACK: ins_pos_c = len_c;
      default:      ins_pos_c = '0;
    endcase
    case (in_func)
      FN_ERASE: del_pos_c = pos_c;
      default:  del_pos_c = '0;
    endcase
  end

  // command sequencer
  always_comb begin
    state_nxt  = state_r;
    len_nxt    = len_r;
    rd_ptr_nxt = rd_ptr_r;
    end_nxt    = end_r;
    last_nxt   = last_r;
    pos_nxt    = pos_r;
    rd_on_nxt  = rd_on_r;
    vld_nxt    = vld_r;
    up_nxt     = up_r;
    word_nxt   = word_r;
    mem_we     = 1'b0;
    mem_wa     = '0;
    mem_wd     = '0;
    done       = 1'b0;
    res_status = ST_OK;
    res_found  = '0;

    // sequential read walk shared by shift and find
    if (state_r == S_SHIFT || state_r == S_FIND) begin
      vld_nxt = rd_on_r;
      if (rd_on_r) begin
        last_nxt = rd_ptr_r;
        if (rd_ptr_r == end_r) begin
          rd_on_nxt = 1'b0;
        end else begin
          rd_ptr_nxt = up_r ? (rd_ptr_r - AW'(1)) : (rd_ptr_r + AW'(1));
        end
      end
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_take) begin
          done = 1'b1;
          case (in_func) inside
            FN_INSERT, FN_PUSH_BACK, FN_PUSH_FRONT: begin
              if (full) begin
                res_status = ST_FULL;
              end else if (ins_pos_c > len_c) begin
                res_status = ST_RANGE;
              end else if (ins_pos_c == len_c) begin
                mem_we  = 1'b1;
                mem_wa  = AW'(len_r);
                mem_wd  = word_in;
                len_nxt = len_r + LW'(1);
              end else begin
                done       = 1'b0;
                state_nxt  = S_SHIFT;
                up_nxt     = 1'b1;
                rd_ptr_nxt = AW'(len_r - LW'(1));
                end_nxt    = AW'(ins_pos_c);
                pos_nxt    = AW'(ins_pos_c);
                word_nxt   = word_in;
                rd_on_nxt  = 1'b1;
                vld_nxt    = 1'b0;
              end
            end
            FN_ERASE, FN_POP_FRONT: begin
              if (empty) begin
                res_status = ST_EMPTY;
              end else if (del_pos_c >= len_c) begin
                res_status = ST_RANGE;
              end else if (del_pos_c == len_c - CW'(1)) begin
                len_nxt = len_r - LW'(1);
              end else begin
                done       = 1'b0;
                state_nxt  = S_SHIFT;
                up_nxt     = 1'b0;
                rd_ptr_nxt = AW'(del_pos_c + CW'(1));
                end_nxt    = AW'(len_r - LW'(1));
                rd_on_nxt  = 1'b1;
                vld_nxt    = 1'b0;
              end
            end
            FN_POP_BACK: begin
              if (empty) begin
                res_status = ST_EMPTY;
              end else begin
                len_nxt = len_r - LW'(1);
              end
            end
            FN_MODIFY: begin
              if (empty) begin
                res_status = ST_EMPTY;
              end else if (pos_c >= len_c) begin
                res_status = ST_RANGE;
              end else begin
                mem_we = 1'b1;
                mem_wa = AW'(pos_c);
                mem_wd = word_in;
              end
            end
            FN_FIND: begin
              if (empty) begin
                res_status = ST_NOTFOUND;
              end else begin
                done       = 1'b0;
                state_nxt  = S_FIND;
                up_nxt     = 1'b0;
                rd_ptr_nxt = '0;
                end_nxt    = AW'(len_r - LW'(1));
                word_nxt   = word_in;
                rd_on_nxt  = 1'b1;
                vld_nxt    = 1'b0;
              end
            end
            default: begin
              res_status = ST_OK;
            end
          endcase
        end
      end

      // move each read word one place up or down
      S_SHIFT: begin
        if (vld_r) begin
          mem_we = 1'b1;
          mem_wa = up_r ? (last_r + AW'(1)) : (last_r - AW'(1));
          mem_wd = mem_rd_data_r;
          if (!rd_on_r) begin
            if (up_r) begin
              state_nxt = S_FILL;
            end else begin
              state_nxt = S_IDLE;
              len_nxt   = len_r - LW'(1);
              done      = 1'b1;
            end
          end
        end
      end

      // drop the new word into the opened gap
      S_FILL: begin
        mem_we    = 1'b1;
        mem_wa    = pos_r;
        mem_wd    = word_r;
        len_nxt   = len_r + LW'(1);
        state_nxt = S_IDLE;
        done      = 1'b1;
      end

      // compare one registered entry per cycle, first hit wins
      S_FIND: begin
        if (vld_r) begin
          if (mem_rd_data_r == word_r) begin
            res_found = last_r;
            state_nxt = S_IDLE;
            done      = 1'b1;
          end else if (!rd_on_r) begin
            res_status = ST_NOTFOUND;
            state_nxt  = S_IDLE;
            done       = 1'b1;
          end
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // result register next value
  always_comb begin
    out_valid_nxt  = out_valid_r;
    out_status_nxt = out_status_r;
    out_found_nxt  = out_found_r;
    out_count_nxt  = out_count_r;
    if (done) begin
      out_valid_nxt  = 1'b1;
      out_status_nxt = res_status;
      out_found_nxt  = FOUND_W'(res_found);
      out_count_nxt  = COUNT_W'(len_nxt);
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt  = 1'b0;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      len_r       <= '0;
      rd_on_r     <= 1'b0;
      vld_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      len_r       <= len_nxt;
      rd_on_r     <= rd_on_nxt;
      vld_r       <= vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    rd_ptr_r     <= rd_ptr_nxt;
    end_r        <= end_nxt;
    last_r       <= last_nxt;
    pos_r        <= pos_nxt;
    up_r         <= up_nxt;
    word_r       <= word_nxt;
    out_status_r <= out_status_nxt;
    out_found_r  <= out_found_nxt;
    out_count_r  <= out_count_nxt;
  end

  // storage: one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    mem_rd_data_r <= mem[rd_ptr_r];
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_found_index = out_found_r;
  assign out_count       = out_count_r;

  // checks
  `PAL_ASSERT_IMP(a_busy_stalls, state_r != S_IDLE, in_stall, "input taken while busy")
  `PAL_ASSERT_IMP(a_count_tracks, out_valid_r, out_count_r == COUNT_W'(len_r),
                  "count beat differs from list length")
  `PAL_ASSERT_IMP(a_len_step, $past(rst_n) && (len_r != $past(len_r)),
                  (len_r == $past(len_r) + LW'(1)) || (len_r == $past(len_r) - LW'(1)),
                  "length moved by more than one")
  `PAL_ASSERT_NXT(a_find_scans, in_take && (in_func == FN_FIND) && !empty,
                  state_r == S_FIND, "find on a filled list did not start a scan")

endmodule

`default_nettype wire
